// ===== src/sdsr_pkg.sv =====
// Shared types and constants for the sprite depth sort block.
package sdsr_pkg;

    // Sheet handle that marks a sprite as invalid.
    localparam logic [15:0] SHEET_INVALID = 16'hFFFF;

    // Blend mode codes.
    localparam logic [1:0] BLEND_ALPHA    = 2'd0;
    localparam logic [1:0] BLEND_ADDITIVE = 2'd1;
    localparam logic [1:0] BLEND_FLAME    = 2'd2;
    localparam logic [1:0] BLEND_SMOKE    = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] REG_EYE_X = 2'd0;
    localparam logic [1:0] REG_EYE_Y = 2'd1;
    localparam logic [1:0] REG_EYE_Z = 2'd2;

    // Depth of the queue between the front and the back.
    localparam int QDEPTH = 4;
    localparam int QPW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    localparam int DIST_W = 51;

    typedef struct packed {
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [23:0] pos_z;
        logic [15:0]        sheet_id;
        logic [1:0]         blend_mode;
        logic               frame_end;
    } t_sprite_in;

    typedef struct packed {
        logic [5:0]  sprite_index;
        logic        run_start;
        logic        additive;
        logic        empty_res;
        logic [15:0] refused_total;
        logic        last_result;
    } t_result;

    // One classified sprite as it waits between the front and the back.
    typedef struct packed {
        logic [DIST_W-1:0] sq_dist;
        logic [15:0]       sheet_id;
        logic [1:0]        blend_mode;
        logic              frame_end;
    } t_entry;

endpackage

// ===== src/sdsr_front.sv =====
// Front part: accepts sprites and computes the squared eye distance.
module sdsr_front
    import sdsr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  t_sprite_in         i_item,
    input  logic signed [23:0] i_eye_x,
    input  logic signed [23:0] i_eye_y,
    input  logic signed [23:0] i_eye_z,
    input  logic [QCW-1:0]     i_q_count,
    output logic               o_full,
    output logic               o_q_write,
    output t_entry             o_q_entry
);

    logic                        w_accept;
    logic [QCW+1:0]              w_used;
    logic [24:0]                 w_mag [3];
    logic signed [23:0]          w_pos [3];
    logic signed [23:0]          w_eye [3];
    logic signed [24:0]          w_diff [3];

    logic                        r_a_valid;
    logic [24:0]                 r_a_mag [3];
    logic [15:0]                 r_a_sheet;
    logic [1:0]                  r_a_blend;
    logic                        r_a_end;

    logic                        r_b_valid;
    logic [49:0]                 r_b_sq [3];
    logic [15:0]                 r_b_sheet;
    logic [1:0]                  r_b_blend;
    logic                        r_b_end;

    // Queue slots are reserved for every sprite still in the pipeline.
    assign w_used   = (QCW+2)'(i_q_count) + (QCW+2)'(r_a_valid) + (QCW+2)'(r_b_valid);
    assign o_full   = w_used >= (QCW+2)'(QDEPTH);
    assign w_accept = i_push && !o_full;

    assign w_pos[0] = i_item.pos_x;
    assign w_pos[1] = i_item.pos_y;
    assign w_pos[2] = i_item.pos_z;
    assign w_eye[0] = i_eye_x;
    assign w_eye[1] = i_eye_y;
    assign w_eye[2] = i_eye_z;

    // Absolute difference on each axis, one extra bit for the range.
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_diff[a] = 25'(w_pos[a]) - 25'(w_eye[a]);
            w_mag[a]  = w_diff[a][24] ? 25'(-w_diff[a]) : 25'(w_diff[a]);
        end
    end

    // Stage one holds the magnitudes, stage two the squares.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_a_valid <= w_accept;
            r_b_valid <= r_a_valid;
        end
        r_a_mag   <= w_mag;
        r_a_sheet <= i_item.sheet_id;
        r_a_blend <= i_item.blend_mode;
        r_a_end   <= i_item.frame_end;
        for (int a = 0; a < 3; a++) begin
            r_b_sq[a] <= r_a_mag[a] * r_a_mag[a];
        end
        r_b_sheet <= r_a_sheet;
        r_b_blend <= r_a_blend;
        r_b_end   <= r_a_end;
    end

    // The sum of the squares goes straight into the queue.
    assign o_q_write            = r_b_valid;
    assign o_q_entry.sq_dist    = DIST_W'(r_b_sq[0]) + DIST_W'(r_b_sq[1]) + DIST_W'(r_b_sq[2]);
    assign o_q_entry.sheet_id   = r_b_sheet;
    assign o_q_entry.blend_mode = r_b_blend;
    assign o_q_entry.frame_end  = r_b_end;

endmodule

// ===== src/sdsr_queue.sv =====
// Short queue that decouples the front from the back.
module sdsr_queue
    import sdsr_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_write,
    input  t_entry         i_entry,
    input  logic           i_read,
    output logic           o_empty,
    output logic [QCW-1:0] o_count,
    output t_entry         o_entry
);

    t_entry           r_slot [QDEPTH];
    logic [QPW-1:0]   r_wr;
    logic [QPW-1:0]   r_rd;
    logic [QCW-1:0]   r_count;

    assign o_empty = r_count == '0;
    assign o_count = r_count;
    assign o_entry = r_slot[r_rd];

    // Pointers and fill count; the front never writes into a full queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_write) begin
                r_wr <= QPW'((32'(r_wr) + 1) % QDEPTH);
            end
            if (i_read) begin
                r_rd <= QPW'((32'(r_rd) + 1) % QDEPTH);
            end
            r_count <= r_count + QCW'(i_write) - QCW'(i_read);
        end
        if (i_write) begin
            r_slot[r_wr] <= i_entry;
        end
    end

endmodule

// ===== src/sdsr_back.sv =====
// Back part: stores sprites and emits them farthest first by selection.
module sdsr_back
    import sdsr_pkg::*;
#(
    parameter int MAX_SPRITES = 64
)(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_empty,
    input  t_entry  i_q_entry,
    output logic    o_q_pop,
    input  logic    i_pop,
    output logic    o_empty,
    output t_result o_result
);

    localparam int IW = $clog2(MAX_SPRITES);
    localparam int CW = $clog2(MAX_SPRITES + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_ATTR,
        ST_EMIT
    } t_state;

    t_state              r_state;
    logic [CW-1:0]       r_count;
    logic [15:0]         r_refused;
    logic [MAX_SPRITES-1:0] r_done;
    logic [CW-1:0]       r_scan;
    logic                r_rd_valid;
    logic [IW-1:0]       r_rd_idx;
    logic                r_have;
    logic [DIST_W-1:0]   r_best_d;
    logic [IW-1:0]       r_best;
    logic [CW-1:0]       r_k;
    logic [17:0]         r_prev_attr;
    logic                r_out_valid;
    t_result             r_out;

    logic [DIST_W-1:0]   mem_dist [MAX_SPRITES];
    logic [17:0]         mem_attr [MAX_SPRITES];
    logic [DIST_W-1:0]   r_dist_q;
    logic [17:0]         r_attr_q;

    logic                w_out_free;
    logic                w_store;
    logic                w_full;
    logic [CW-1:0]       n_count;
    logic [1:0]          w_blend;
    logic                w_empty_frame;
    logic                w_emit;

    assign w_out_free    = !r_out_valid || i_pop;
    assign o_q_pop       = (r_state == ST_IDLE) && !i_q_empty && w_out_free;
    assign w_full        = r_count >= CW'(MAX_SPRITES);
    assign w_store       = o_q_pop && !w_full && (i_q_entry.sheet_id != SHEET_INVALID);
    assign n_count       = r_count + CW'(w_store);
    assign w_blend       = r_attr_q[17:16];
    assign w_empty_frame = o_q_pop && i_q_entry.frame_end && (n_count == '0);
    assign w_emit        = (r_state == ST_EMIT) && w_out_free;
    assign o_empty       = !r_out_valid;
    assign o_result      = r_out;

    // Distance and attribute stores, each read through a register.
    always_ff @(posedge i_clk) begin
        if (w_store) begin
            mem_dist[r_count[IW-1:0]] <= i_q_entry.sq_dist;
            mem_attr[r_count[IW-1:0]] <= {i_q_entry.blend_mode, i_q_entry.sheet_id};
        end
        r_dist_q <= mem_dist[r_scan[IW-1:0]];
        r_attr_q <= mem_attr[r_best];
    end

    // Sequencer: load, scan for the farthest remaining sprite, emit it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_refused   <= '0;
            r_out_valid <= 1'b0;
            r_rd_valid  <= 1'b0;
            r_have      <= 1'b0;
            r_done      <= '0;
            r_scan      <= '0;
            r_k         <= '0;
        end else begin
            // A new result replaces the one being taken.
            if (w_empty_frame || w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end

            // Keep the farthest candidate; a tie keeps the lower index.
            if (r_rd_valid && !r_done[r_rd_idx] && (!r_have || r_dist_q > r_best_d)) begin
                r_have   <= 1'b1;
                r_best_d <= r_dist_q;
                r_best   <= r_rd_idx;
            end

            unique case (r_state)
                ST_IDLE: begin
                    r_rd_valid <= 1'b0;
                    if (o_q_pop) begin
                        r_count <= n_count;
                        if (w_full && r_refused != 16'hFFFF) begin
                            r_refused <= r_refused + 16'd1;
                        end
                        if (i_q_entry.frame_end) begin
                            if (n_count == '0) begin
                                r_out <= '{sprite_index: '0, run_start: 1'b0,
                                           additive: 1'b0, empty_res: 1'b1,
                                           refused_total: r_refused,
                                           last_result: 1'b1};
                            end else begin
                                r_state <= ST_SCAN;
                                r_scan  <= '0;
                                r_k     <= '0;
                                r_done  <= '0;
                                r_have  <= 1'b0;
                            end
                        end
                    end
                end
                ST_SCAN: begin
                    r_rd_valid <= 1'b1;
                    r_rd_idx   <= r_scan[IW-1:0];
                    r_scan     <= r_scan + CW'(1);
                    if (r_scan == r_count - CW'(1)) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    r_rd_valid <= 1'b0;
                    r_state    <= ST_ATTR;
                end
                ST_ATTR: begin
                    r_state <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (w_out_free) begin
                        r_out <= '{sprite_index: 6'(r_best),
                                   run_start: (r_k == '0) || (r_attr_q != r_prev_attr),
                                   additive: (w_blend == BLEND_ADDITIVE) ||
                                             (w_blend == BLEND_FLAME),
                                   empty_res: 1'b0,
                                   refused_total: r_refused,
                                   last_result: r_k == r_count - CW'(1)};
                        r_prev_attr         <= r_attr_q;
                        r_done[r_best]      <= 1'b1;
                        r_have              <= 1'b0;
                        r_scan              <= '0;
                        r_k                 <= r_k + CW'(1);
                        if (r_k == r_count - CW'(1)) begin
                            r_state <= ST_IDLE;
                            r_count <= '0;
                        end else begin
                            r_state <= ST_SCAN;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // The store never holds more sprites than its capacity.
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_SPRITES))
        else $error("sprite count above capacity");

    // No queue entry is taken while a sort is under way.
    a_no_pop_sort: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_q_pop)
        else $error("queue popped during sort");

    // Every emitted sprite index lies inside the stored frame.
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && w_out_free) |-> (CW'(r_best) < r_count))
        else $error("emitted index outside the frame");

endmodule

// ===== src/sprite_depth_sort_runs.sv =====
// Top level of the sprite depth sort: configuration port and the three parts.
//
//  Channel   Direction  Handshake            Payload
//  sprite    in         push / full          i_sprite (t_sprite_in)
//  result    out        empty / pop          o_result (t_result)
//  config    in         psel/penable/pready  paddr, pwdata, prdata
//
// An accepted sprite passes the magnitude and square registers before it
// reaches the queue; sprites can be pushed every cycle while the four-entry
// queue has room. Each result of a frame scans the distance store through
// its single read port once. No sprites are loaded during a sort.
// Reset clears the counts and the eye position; the stores need no clearing.
module sprite_depth_sort_runs
    import sdsr_pkg::*;
#(
    parameter int MAX_SPRITES = 64
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  t_sprite_in  i_sprite,
    output logic        empty,
    input  logic        pop,
    output t_result     o_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic signed [23:0] r_eye_x;
    logic signed [23:0] r_eye_y;
    logic signed [23:0] r_eye_z;
    logic [1:0]         w_reg;
    logic               w_q_write;
    t_entry             w_q_in;
    t_entry             w_q_out;
    logic               w_q_pop;
    logic               w_q_empty;
    logic [QCW-1:0]     w_q_count;

    assign pready = 1'b1;
    assign w_reg  = paddr[3:2];

    // Eye position registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eye_x <= '0;
            r_eye_y <= '0;
            r_eye_z <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (w_reg)
                REG_EYE_X: r_eye_x <= pwdata[23:0];
                REG_EYE_Y: r_eye_y <= pwdata[23:0];
                REG_EYE_Z: r_eye_z <= pwdata[23:0];
                default: begin
                end
            endcase
        end
    end

    // Register read back, sign extended.
    always_comb begin
        unique case (w_reg)
            REG_EYE_X: prdata = 32'(r_eye_x);
            REG_EYE_Y: prdata = 32'(r_eye_y);
            REG_EYE_Z: prdata = 32'(r_eye_z);
            default:   prdata = '0;
        endcase
    end

    sdsr_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_item    (i_sprite),
        .i_eye_x   (r_eye_x),
        .i_eye_y   (r_eye_y),
        .i_eye_z   (r_eye_z),
        .i_q_count (w_q_count),
        .o_full    (full),
        .o_q_write (w_q_write),
        .o_q_entry (w_q_in)
    );

    sdsr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_write (w_q_write),
        .i_entry (w_q_in),
        .i_read  (w_q_pop),
        .o_empty (w_q_empty),
        .o_count (w_q_count),
        .o_entry (w_q_out)
    );

    sdsr_back #(
        .MAX_SPRITES (MAX_SPRITES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (w_q_empty),
        .i_q_entry (w_q_out),
        .o_q_pop   (w_q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (o_result)
    );

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the sprite depth sort block.
module tb_top;
    import sdsr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY    = 64;
    localparam int CYCLE_LIMIT = 600000;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    t_sprite_in  i_sprite;
    logic        empty;
    logic        pop;
    t_result     o_result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    sprite_depth_sort_runs #(.MAX_SPRITES(CAPACITY)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .push(push), .full(full), .i_sprite(i_sprite),
        .empty(empty), .pop(pop), .o_result(o_result),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Sprites waiting to be pushed and draw results waiting to be popped.
    t_sprite_in sprite_q[$];
    t_result    draw_q[$];

    // Shadow copy of the block's state.
    logic signed [23:0] cam_x, cam_y, cam_z;
    logic [50:0]        depth_mem[CAPACITY];
    logic [17:0]        attr_mem[CAPACITY];
    int unsigned        stored_cnt = 0;
    logic [15:0]        refused_cnt = '0;

    int  errors = 0;
    int  cycles = 0;
    bit  calm;
    int  push_gap;
    int  pop_gap;
    logic signed [23:0] last_x, last_y, last_z;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Append to the pending sprites and to the expected results.
    function automatic void enqueue_sprite(t_sprite_in s);
        sprite_q = {sprite_q, s};
    endfunction

    function automatic void expect_result(t_result r);
        draw_q = {draw_q, r};
    endfunction

    // Idle length: mostly short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [50:0] sq_distance(t_sprite_in s);
        longint dx, dy, dz;
        dx = longint'(s.pos_x) - longint'(cam_x);
        dy = longint'(s.pos_y) - longint'(cam_y);
        dz = longint'(s.pos_z) - longint'(cam_z);
        return 51'(dx * dx + dy * dy + dz * dz);
    endfunction

    // Store one accepted sprite and, on frame end, queue the sorted draw list.
    function automatic void predict_frame(t_sprite_in s);
        bit          taken[CAPACITY];
        int          best;
        logic [17:0] prev_attr;
        t_result     r;
        if (stored_cnt >= CAPACITY) begin
            if (refused_cnt != 16'hFFFF) refused_cnt++;
        end else if (s.sheet_id != SHEET_INVALID) begin
            depth_mem[stored_cnt] = sq_distance(s);
            attr_mem[stored_cnt]  = {s.blend_mode, s.sheet_id};
            stored_cnt++;
        end
        if (!s.frame_end) return;
        if (stored_cnt == 0) begin
            r = '0;
            r.empty_res     = 1'b1;
            r.refused_total = refused_cnt;
            r.last_result   = 1'b1;
            expect_result(r);
            return;
        end
        prev_attr = '0;
        for (int k = 0; k < stored_cnt; k++) begin
            // Farthest first; a strict compare keeps the lower index on ties.
            best = -1;
            for (int j = 0; j < stored_cnt; j++)
                if (!taken[j] && (best < 0 || depth_mem[j] > depth_mem[best]))
                    best = j;
            taken[best] = 1'b1;
            r = '0;
            r.sprite_index  = 6'(best);
            r.run_start     = (k == 0) || (attr_mem[best] != prev_attr);
            r.additive      = (attr_mem[best][17:16] == BLEND_ADDITIVE) ||
                              (attr_mem[best][17:16] == BLEND_FLAME);
            r.refused_total = refused_cnt;
            r.last_result   = (k + 1 == stored_cnt);
            expect_result(r);
            prev_attr = attr_mem[best];
        end
        stored_cnt = 0;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d (t=%0t)", what, got, want, $realtime);
        errors++;
    endtask

    // Sprite driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push     <= 1'b0;
            i_sprite <= '0;
            push_gap = 0;
        end else begin
            if (push && !full) predict_frame(i_sprite);
            if (push && full) begin
                // Hold the request until it is taken.
            end else if (push_gap > 0) begin
                push_gap--;
                push <= 1'b0;
            end else if (sprite_q.size() > 0) begin
                i_sprite <= sprite_q.pop_front();
                push     <= 1'b1;
                push_gap = pick_gap();
            end else begin
                push <= 1'b0;
            end
        end
    end

    // Result monitor and pop driver.
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            pop <= 1'b0;
            pop_gap = 0;
        end else begin
            if (pop && !empty) begin
                if (draw_q.size() == 0) begin
                    report_mismatch("unexpected result, index", o_result.sprite_index, -1);
                end else begin
                    want = draw_q.pop_front();
                    if (o_result.sprite_index != want.sprite_index)
                        report_mismatch("sprite_index", o_result.sprite_index, want.sprite_index);
                    if (o_result.run_start != want.run_start)
                        report_mismatch("run_start", o_result.run_start, want.run_start);
                    if (o_result.additive != want.additive)
                        report_mismatch("additive", o_result.additive, want.additive);
                    if (o_result.empty_res != want.empty_res)
                        report_mismatch("empty_res", o_result.empty_res, want.empty_res);
                    if (o_result.refused_total != want.refused_total)
                        report_mismatch("refused_total", o_result.refused_total,
                                        want.refused_total);
                    if (o_result.last_result != want.last_result)
                        report_mismatch("last_result", o_result.last_result, want.last_result);
                end
            end
            if (pop_gap > 0) begin
                pop_gap--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
                pop_gap = pick_gap();
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    function automatic t_sprite_in make_sprite(logic [15:0] sheet, bit last);
        t_sprite_in s;
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            s.pos_x = 24'($urandom);
            s.pos_y = 24'($urandom);
            s.pos_z = 24'($urandom);
        end else if (r < 88) begin
            s.pos_x = cam_x + 24'($signed(5'($urandom)));
            s.pos_y = cam_y + 24'($signed(5'($urandom)));
            s.pos_z = cam_z + 24'($signed(5'($urandom)));
        end else begin
            // Same spot as the previous sprite gives a distance tie.
            s.pos_x = last_x;
            s.pos_y = last_y;
            s.pos_z = last_z;
        end
        last_x = s.pos_x;
        last_y = s.pos_y;
        last_z = s.pos_z;
        s.sheet_id   = sheet;
        s.blend_mode = 2'($urandom);
        s.frame_end  = last;
        return s;
    endfunction

    function automatic logic [15:0] pick_sheet();
        int r;
        r = $urandom_range(0, 99);
        if (r < 6) return SHEET_INVALID;
        if (r < 70) return 16'($urandom_range(1, 3));
        return 16'($urandom_range(0, 16'hFFFE));
    endfunction

    // One frame of n sprites; n == 0 sends a lone invalid sprite as frame end.
    task automatic queue_frame(int n);
        if (n == 0) begin
            enqueue_sprite(make_sprite(SHEET_INVALID, 1'b1));
            return;
        end
        for (int i = 0; i < n; i++)
            enqueue_sprite(make_sprite(pick_sheet(), i == n - 1));
    endtask

    task automatic write_eye(logic [1:0] idx, logic signed [23:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{8{value[23]}}, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_EYE_X: cam_x = value;
            REG_EYE_Y: cam_y = value;
            default:   cam_z = value;
        endcase
    endtask

    task automatic set_camera(logic signed [23:0] x, logic signed [23:0] y,
                              logic signed [23:0] z);
        write_eye(REG_EYE_X, x);
        write_eye(REG_EYE_Y, y);
        write_eye(REG_EYE_Z, z);
    endtask

    // Let the sender drain and every result come back before moving on.
    task automatic drain();
        while (sprite_q.size() > 0 || push || draw_q.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    initial begin
        int sent;
        t_sprite_in s;
        i_rst_n  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        cam_x = '0; cam_y = '0; cam_z = '0;
        last_x = '0; last_y = '0; last_z = '0;
        calm   = 1'b1;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty frame at reset camera, then extremes against a far corner.
        queue_frame(0);
        drain();
        set_camera(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
        s = '0;
        s.pos_x = 24'sh800000; s.pos_y = 24'sh800000; s.pos_z = 24'sh800000;
        s.sheet_id = 16'hFFFE; s.blend_mode = BLEND_SMOKE;
        enqueue_sprite(s);
        s.pos_x = 24'sh7FFFFF; s.pos_y = 24'sh7FFFFF; s.pos_z = 24'sh7FFFFF;
        s.sheet_id = 16'h0000; s.blend_mode = BLEND_ALPHA;
        enqueue_sprite(s);
        s.sheet_id = SHEET_INVALID; s.blend_mode = BLEND_ADDITIVE;
        enqueue_sprite(s);
        s.pos_x = 24'sh7FFFFE; s.sheet_id = 16'h0000; s.blend_mode = BLEND_ALPHA;
        enqueue_sprite(s);
        s.blend_mode = BLEND_ADDITIVE;
        enqueue_sprite(s);
        s.blend_mode = BLEND_FLAME;
        enqueue_sprite(s);
        s.sheet_id = 16'h5555;
        enqueue_sprite(s);
        // Frame end on a dropped sprite still emits the sort.
        s.sheet_id = SHEET_INVALID; s.frame_end = 1'b1;
        enqueue_sprite(s);
        drain();
        set_camera(24'sh800000, 24'sh800000, 24'sh800000);
        s.sheet_id = 16'hAAAA; s.blend_mode = BLEND_FLAME; s.frame_end = 1'b0;
        enqueue_sprite(s);
        s.pos_x = 24'sh800000; s.pos_y = 24'sh800000; s.pos_z = 24'sh800000;
        s.frame_end = 1'b1;
        enqueue_sprite(s);
        drain();

        // Random frames under several camera settings.
        sent = 12;
        for (int phase = 0; phase < 6; phase++) begin
            calm = (phase == 2);
            case (phase)
                0: set_camera('0, '0, '0);
                3: set_camera(24'sh7FFFFF, 24'sh800000, 24'sh000000);
                default: set_camera(24'($urandom), 24'($urandom), 24'($urandom));
            endcase
            for (int f = 0; f < 4; f++) begin
                int n;
                n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 7);
                queue_frame(n);
                sent += (n == 0) ? 1 : n;
            end
            // One overfull frame exercises refusal, including invalid sheets.
            if (phase == 4) begin
                for (int i = 0; i < CAPACITY; i++)
                    enqueue_sprite(make_sprite(pick_sheet() & 16'h7FFF, 1'b0));
                enqueue_sprite(make_sprite(16'h0004, 1'b0));
                enqueue_sprite(make_sprite(SHEET_INVALID, 1'b0));
                enqueue_sprite(make_sprite(16'h0002, 1'b1));
                sent += CAPACITY + 3;
            end
            drain();
        end
        calm = 1'b0;
        while (sent < 170) begin
            int n;
            n = $urandom_range(1, 5);
            queue_frame(n);
            sent += n;
            drain();
        end

        drain();
        if (errors == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
